@@ design/rqr_pkg.sv @@
package rqr_pkg;

    localparam int FRAC_BITS = 14;

    // quotient bits: integer bit, FRAC_BITS fraction bits and one rounding bit
    localparam int QB     = FRAC_BITS + 2;
    localparam int RND_W  = FRAC_BITS + 1;
    localparam int NSTAGE = QB + 6;
    localparam int LANES  = 6;

    localparam logic [RND_W-1:0] LIM =
        (FRAC_BITS >= 15) ? RND_W'(32767) : RND_W'(1) << FRAC_BITS;

    localparam int PW = 34;   // relative quaternion component
    localparam int QW = 31;   // component after range shift
    localparam int MW = 62;   // product of two shifted components
    localparam int NW = 63;   // squared norm and numerator magnitude

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
    } t_side;

endpackage

@@ design/rqr_quat_mul.sv @@
module rqr_quat_mul (
    input  logic                         i_clk,
    input  logic [1:0]                   i_en,
    input  logic signed [15:0]           i_r [4],
    input  logic signed [15:0]           i_t [4],
    output logic signed [rqr_pkg::PW-1:0] o_p [4]
);

    localparam int PW = rqr_pkg::PW;

    logic signed [31:0]          r_prod [4][4];
    logic signed [rqr_pkg::PW-1:0] r_p [4];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i][j] <= 32'(i_r[i] * i_t[j]);
                end
            end
        end
    end

    // conj(r) * t, index order w, x, y, z
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_p[0] <= PW'(r_prod[0][0]) + PW'(r_prod[1][1]) + PW'(r_prod[2][2])
                    + PW'(r_prod[3][3]);
            r_p[1] <= PW'(r_prod[0][1]) - PW'(r_prod[1][0]) - PW'(r_prod[2][3])
                    + PW'(r_prod[3][2]);
            r_p[2] <= PW'(r_prod[0][2]) + PW'(r_prod[1][3]) - PW'(r_prod[2][0])
                    - PW'(r_prod[3][1]);
            r_p[3] <= PW'(r_prod[0][3]) - PW'(r_prod[1][2]) + PW'(r_prod[2][1])
                    - PW'(r_prod[3][0]);
        end
    end

    assign o_p = r_p;

endmodule

@@ design/rqr_norm.sv @@
module rqr_norm (
    input  logic                          i_clk,
    input  logic [2:0]                    i_en,
    input  logic signed [rqr_pkg::PW-1:0] i_p [4],
    output logic [rqr_pkg::NW-1:0]        o_n,
    output logic [rqr_pkg::NW-1:0]        o_mag [rqr_pkg::LANES],
    output rqr_pkg::t_side                o_side
);

    logic [rqr_pkg::PW-1:0]        mag [4];
    logic [1:0]                    shamt;
    logic                          fit0, fit1, fit2;
    logic signed [rqr_pkg::QW-1:0] r_q [4];
    logic                          r_zero_a, r_zero_b;
    logic signed [rqr_pkg::MW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_zw, r_xz, r_yw, r_yz, r_xw;
    logic signed [63:0]            num [rqr_pkg::LANES];
    logic signed [63:0]            nsum;
    logic [rqr_pkg::NW-1:0]        r_n;
    logic [rqr_pkg::NW-1:0]        r_mag [rqr_pkg::LANES];
    rqr_pkg::t_side                r_side;

    always_comb begin
        fit0 = 1'b1;
        fit1 = 1'b1;
        fit2 = 1'b1;
        for (int i = 0; i < 4; i++) begin
            mag[i] = i_p[i][rqr_pkg::PW-1] ? -i_p[i] : i_p[i];
            fit0 = fit0 & (mag[i][33:30] == 4'd0);
            fit1 = fit1 & (mag[i][33:31] == 3'd0);
            fit2 = fit2 & (mag[i][33:32] == 2'd0);
        end
        shamt = fit0 ? 2'd0 : fit1 ? 2'd1 : fit2 ? 2'd2 : 2'd3;
    end

    // arithmetic shift gives floor rounding
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 4; i++) begin
                r_q[i] <= rqr_pkg::QW'(i_p[i] >>> shamt);
            end
            r_zero_a <= (i_p[0] == '0) && (i_p[1] == '0) && (i_p[2] == '0) && (i_p[3] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ww <= r_q[0] * r_q[0];
            r_xx <= r_q[1] * r_q[1];
            r_yy <= r_q[2] * r_q[2];
            r_zz <= r_q[3] * r_q[3];
            r_xy <= r_q[1] * r_q[2];
            r_zw <= r_q[3] * r_q[0];
            r_xz <= r_q[1] * r_q[3];
            r_yw <= r_q[2] * r_q[0];
            r_yz <= r_q[2] * r_q[3];
            r_xw <= r_q[1] * r_q[0];
            r_zero_b <= r_zero_a;
        end
    end

    always_comb begin
        nsum   = 64'(r_ww) + 64'(r_xx) + 64'(r_yy) + 64'(r_zz);
        num[0] = 64'(r_ww) + 64'(r_xx) - 64'(r_yy) - 64'(r_zz);
        num[1] = (64'(r_xy) - 64'(r_zw)) <<< 1;
        num[2] = (64'(r_xy) + 64'(r_zw)) <<< 1;
        num[3] = 64'(r_ww) - 64'(r_xx) + 64'(r_yy) - 64'(r_zz);
        num[4] = (64'(r_xz) - 64'(r_yw)) <<< 1;
        num[5] = (64'(r_yz) + 64'(r_xw)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_n <= nsum[rqr_pkg::NW-1:0];
            for (int i = 0; i < rqr_pkg::LANES; i++) begin
                r_mag[i]        <= num[i][63] ? rqr_pkg::NW'(-num[i]) : num[i][rqr_pkg::NW-1:0];
                r_side.neg[i]   <= num[i][63];
            end
            r_side.zero <= r_zero_b;
        end
    end

    assign o_n    = r_n;
    assign o_mag  = r_mag;
    assign o_side = r_side;

endmodule

@@ design/rqr_divider.sv @@
module rqr_divider (
    input  logic                   i_clk,
    input  logic [rqr_pkg::QB-1:0] i_en,
    input  logic [rqr_pkg::NW-1:0] i_n,
    input  logic [rqr_pkg::NW-1:0] i_mag [rqr_pkg::LANES],
    input  rqr_pkg::t_side         i_side,
    output logic [rqr_pkg::QB-1:0] o_quo [rqr_pkg::LANES],
    output rqr_pkg::t_side         o_side
);

    logic [rqr_pkg::NW-1:0] r_rem  [rqr_pkg::QB][rqr_pkg::LANES];
    logic [rqr_pkg::QB-1:0] r_quo  [rqr_pkg::QB][rqr_pkg::LANES];
    logic [rqr_pkg::NW-1:0] r_n    [rqr_pkg::QB];
    rqr_pkg::t_side         r_side [rqr_pkg::QB];

    // one restoring step per stage, all six lanes share the divisor
    for (genvar k = 0; k < rqr_pkg::QB; k++) begin : g_step
        logic [rqr_pkg::NW:0]   trial [rqr_pkg::LANES];
        logic [rqr_pkg::QB-1:0] qprev [rqr_pkg::LANES];
        logic [rqr_pkg::NW-1:0] dvs;
        rqr_pkg::t_side         side_in;

        if (k == 0) begin : g_first
            always_comb begin
                dvs     = i_n;
                side_in = i_side;
                for (int l = 0; l < rqr_pkg::LANES; l++) begin
                    trial[l] = {1'b0, i_mag[l]};
                    qprev[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                dvs     = r_n[k-1];
                side_in = r_side[k-1];
                for (int l = 0; l < rqr_pkg::LANES; l++) begin
                    trial[l] = {r_rem[k-1][l], 1'b0};
                    qprev[l] = r_quo[k-1][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_n[k]    <= dvs;
                r_side[k] <= side_in;
                for (int l = 0; l < rqr_pkg::LANES; l++) begin
                    if (trial[l] >= {1'b0, dvs}) begin
                        r_rem[k][l] <= rqr_pkg::NW'(trial[l] - {1'b0, dvs});
                        r_quo[k][l] <= {qprev[l][rqr_pkg::QB-2:0], 1'b1};
                    end else begin
                        r_rem[k][l] <= trial[l][rqr_pkg::NW-1:0];
                        r_quo[k][l] <= {qprev[l][rqr_pkg::QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_quo  = r_quo[rqr_pkg::QB-1];
    assign o_side = r_side[rqr_pkg::QB-1];

endmodule

@@ design/relative_quat_to_rot6d.sv @@
// throughput: one transaction per cycle while the output is not stalled, set by the fully
// pipelined one-bit-per-stage divider
// stalls hold each stage in place; empty stages keep filling while the output waits
// reset (synchronous, active low) clears every stage valid bit; data registers are not reset
module relative_quat_to_rot6d (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // robot_w, robot_x, robot_y, robot_z, target_w, target_x, target_y, target_z
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // m00, m01, m10, m11, m20, m21
    output logic [95:0]  m_axis_tdata,
    // zero_norm
    output logic         m_axis_tuser
);

    localparam int NS = rqr_pkg::NSTAGE;
    localparam int QB = rqr_pkg::QB;

    logic [NS-1:0]           r_valid;
    logic [NS-1:0]           en;
    logic signed [15:0]      rq [4];
    logic signed [15:0]      tq [4];
    logic signed [rqr_pkg::PW-1:0] p [4];
    logic [rqr_pkg::NW-1:0]  n;
    logic [rqr_pkg::NW-1:0]  mag [rqr_pkg::LANES];
    rqr_pkg::t_side          side_norm, side_div;
    logic [QB-1:0]           quo [rqr_pkg::LANES];
    logic [rqr_pkg::RND_W-1:0] rnd [rqr_pkg::LANES];
    logic [31:0]             sat [rqr_pkg::LANES];
    logic [95:0]             n_data;
    logic [95:0]             r_data;
    logic                    r_zero;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rq[i] = s_axis_tdata[16*i +: 16];
            tq[i] = s_axis_tdata[64 + 16*i +: 16];
        end
    end

    // a stage moves when it is empty or the next one moves
    always_comb begin
        en[NS-1] = !r_valid[NS-1] || m_axis_tready;
        for (int k = NS-2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_valid[k] <= (k == 0) ? s_axis_tvalid : r_valid[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    rqr_quat_mul u_mul (
        .i_clk (i_clk),
        .i_en  (en[1:0]),
        .i_r   (rq),
        .i_t   (tq),
        .o_p   (p)
    );

    rqr_norm u_norm (
        .i_clk  (i_clk),
        .i_en   (en[4:2]),
        .i_p    (p),
        .o_n    (n),
        .o_mag  (mag),
        .o_side (side_norm)
    );

    rqr_divider u_div (
        .i_clk  (i_clk),
        .i_en   (en[QB+4:5]),
        .i_n    (n),
        .i_mag  (mag),
        .i_side (side_norm),
        .o_quo  (quo),
        .o_side (side_div)
    );

    // round half away from zero on magnitude, clamp, then restore sign
    always_comb begin
        for (int l = 0; l < rqr_pkg::LANES; l++) begin
            rnd[l] = rqr_pkg::RND_W'((QB+1)'(quo[l]) + (QB+1)'(1) >> 1);
            sat[l] = (rnd[l] > rqr_pkg::LIM) ? 32'(rqr_pkg::LIM) : 32'(rnd[l]);
            if (side_div.zero) begin
                n_data[16*l +: 16] = '0;
            end else if (side_div.neg[l]) begin
                n_data[16*l +: 16] = 16'(-sat[l]);
            end else begin
                n_data[16*l +: 16] = sat[l][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_data <= n_data;
            r_zero <= side_div.zero;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_valid[NS-1];
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_zero;

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero norm result carries nonzero matrix");

    a_m00_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= $signed(17'(rqr_pkg::LIM))
            && $signed(m_axis_tdata[15:0]) >= -$signed(17'(rqr_pkg::LIM)))
        else $error("m00 outside saturation limit");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output side free");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result changed during stall");

endmodule
